@@ rtl/core/mer_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  typedef enum logic {
    OPN_START = 1'b0,
    OPN_STEP  = 1'b1
  } opn_t;

  typedef enum logic [2:0] {
    SH_IDLE,
    SH_POINT,
    SH_VRUN,
    SH_HRUN,
    SH_R1,
    SH_R2
  } shape_t;

  typedef enum logic [3:0] {
    ST_READY,
    ST_SQ_RX,
    ST_SQ_RY,
    ST_MUL_DY,
    ST_INIT_D,
    ST_EMIT,
    ST_STEP,
    ST_R1_D,
    ST_N1,
    ST_N2,
    ST_N3,
    ST_ROUND,
    ST_R2_MOVE,
    ST_R2_D
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_RX,
    OP_SQ_RY,
    OP_MUL_DY,
    OP_INIT_D,
    OP_EMIT,
    OP_INC_X,
    OP_INC_Y,
    OP_R1_MOVE,
    OP_R1_DEC,
    OP_N1,
    OP_N2,
    OP_N3,
    OP_ROUND,
    OP_R2_MOVE
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] quad;
    logic       last;
    logic       done;
    logic       r2_dec;
  } dp_cmd_t;

  typedef struct packed {
    logic rx_zero;
    logic ry_zero;
    logic x_zero;
    logic y_zero;
    logic y_le0;
    logic run_end_x;
    logic run_end_y;
    logic dx_lt_dy;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/mer_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mer_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire logic             operation,
  output logic                  item_stall,
  input  wire mer_pkg::dp_sts_t sts,
  output mer_pkg::dp_cmd_t      cmd
);

  mer_pkg::ctl_state_t state, state_next;
  mer_pkg::shape_t     shape, shape_next;
  logic [1:0]          pt_idx, pt_idx_next;

  logic       more;
  logic [1:0] nxt;
  logic       done_pred;
  logic       ellipse;
  logic       accept;

  assign accept  = item_valid && !item_stall;
  assign ellipse = (shape == mer_pkg::SH_R1) || (shape == mer_pkg::SH_R2);

  // find the next mirrored point of this position
  always_comb begin
    more = 1'b0;
    nxt  = pt_idx;
    if (ellipse) begin
      case (pt_idx)
        2'd0: begin
          if (!sts.x_zero) begin
            more = 1'b1;
            nxt  = 2'd1;
          end else if (!sts.y_zero) begin
            more = 1'b1;
            nxt  = 2'd2;
          end
        end
        2'd1: begin
          if (!sts.y_zero) begin
            more = 1'b1;
            nxt  = 2'd2;
          end
        end
        2'd2: begin
          if (!sts.x_zero) begin
            more = 1'b1;
            nxt  = 2'd3;
          end
        end
        default: begin
          more = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    done_pred = 1'b0;
    case (shape)
      mer_pkg::SH_POINT: done_pred = 1'b1;
      mer_pkg::SH_VRUN:  done_pred = sts.run_end_y;
      mer_pkg::SH_HRUN:  done_pred = sts.run_end_x;
      mer_pkg::SH_R1:    done_pred = !sts.dx_lt_dy && sts.y_le0;
      mer_pkg::SH_R2:    done_pred = sts.y_le0;
      default:           done_pred = 1'b1;
    endcase
  end

  always_comb begin
    state_next  = state;
    shape_next  = shape;
    pt_idx_next = pt_idx;
    unique case (state)
      mer_pkg::ST_READY: begin
        if (accept) begin
          if (operation == mer_pkg::OPN_START) begin
            state_next = mer_pkg::ST_SQ_RX;
          end else if (shape != mer_pkg::SH_IDLE) begin
            state_next  = mer_pkg::ST_EMIT;
            pt_idx_next = 2'd0;
          end
        end
      end
      mer_pkg::ST_SQ_RX: begin
        if (sts.rx_zero && sts.ry_zero) begin
          shape_next = mer_pkg::SH_POINT;
        end else if (sts.rx_zero) begin
          shape_next = mer_pkg::SH_VRUN;
        end else if (sts.ry_zero) begin
          shape_next = mer_pkg::SH_HRUN;
        end else begin
          shape_next = mer_pkg::SH_R1;
        end
        state_next = mer_pkg::ST_SQ_RY;
      end
      mer_pkg::ST_SQ_RY:  state_next = mer_pkg::ST_MUL_DY;
      mer_pkg::ST_MUL_DY: state_next = mer_pkg::ST_INIT_D;
      mer_pkg::ST_INIT_D: state_next = mer_pkg::ST_READY;
      mer_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          if (more) begin
            pt_idx_next = nxt;
          end else if (done_pred) begin
            shape_next = mer_pkg::SH_IDLE;
            state_next = mer_pkg::ST_READY;
          end else begin
            state_next = mer_pkg::ST_STEP;
          end
        end
      end
      mer_pkg::ST_STEP: begin
        case (shape)
          mer_pkg::SH_R1: begin
            state_next = sts.dx_lt_dy ? mer_pkg::ST_R1_D : mer_pkg::ST_N1;
          end
          mer_pkg::SH_R2: state_next = mer_pkg::ST_R2_D;
          default:        state_next = mer_pkg::ST_READY;
        endcase
      end
      mer_pkg::ST_R1_D: state_next = mer_pkg::ST_READY;
      mer_pkg::ST_N1:   state_next = mer_pkg::ST_N2;
      mer_pkg::ST_N2:   state_next = mer_pkg::ST_N3;
      mer_pkg::ST_N3:   state_next = mer_pkg::ST_ROUND;
      mer_pkg::ST_ROUND: begin
        shape_next = mer_pkg::SH_R2;
        state_next = mer_pkg::ST_R2_MOVE;
      end
      mer_pkg::ST_R2_MOVE: state_next = mer_pkg::ST_R2_D;
      mer_pkg::ST_R2_D:    state_next = mer_pkg::ST_READY;
      default:             state_next = mer_pkg::ST_READY;
    endcase
  end

  always_comb begin
    item_stall = 1'b1;
    cmd        = '{op: mer_pkg::OP_NONE, quad: pt_idx, last: !more,
                   done: !more && done_pred, r2_dec: 1'b0};
    unique case (state)
      mer_pkg::ST_READY: begin
        item_stall = 1'b0;
        if (item_valid && operation == mer_pkg::OPN_START) begin
          cmd.op = mer_pkg::OP_LOAD;
        end
      end
      mer_pkg::ST_SQ_RX:  cmd.op = mer_pkg::OP_SQ_RX;
      mer_pkg::ST_SQ_RY:  cmd.op = mer_pkg::OP_SQ_RY;
      mer_pkg::ST_MUL_DY: cmd.op = mer_pkg::OP_MUL_DY;
      mer_pkg::ST_INIT_D: cmd.op = mer_pkg::OP_INIT_D;
      mer_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.op = mer_pkg::OP_EMIT;
        end
      end
      mer_pkg::ST_STEP: begin
        case (shape)
          mer_pkg::SH_VRUN: cmd.op = mer_pkg::OP_INC_Y;
          mer_pkg::SH_HRUN: cmd.op = mer_pkg::OP_INC_X;
          mer_pkg::SH_R1: begin
            if (sts.dx_lt_dy) begin
              cmd.op = mer_pkg::OP_R1_MOVE;
            end
          end
          mer_pkg::SH_R2:   cmd.op = mer_pkg::OP_R2_MOVE;
          default:          cmd.op = mer_pkg::OP_NONE;
        endcase
      end
      mer_pkg::ST_R1_D: cmd.op = mer_pkg::OP_R1_DEC;
      mer_pkg::ST_N1:   cmd.op = mer_pkg::OP_N1;
      mer_pkg::ST_N2:   cmd.op = mer_pkg::OP_N2;
      mer_pkg::ST_N3:   cmd.op = mer_pkg::OP_N3;
      mer_pkg::ST_ROUND: cmd.op = mer_pkg::OP_ROUND;
      mer_pkg::ST_R2_MOVE: cmd.op = mer_pkg::OP_R2_MOVE;
      mer_pkg::ST_R2_D: begin
        cmd.op     = mer_pkg::OP_R1_DEC;
        cmd.r2_dec = 1'b1;
      end
      default: cmd.op = mer_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mer_pkg::ST_READY;
      shape  <= mer_pkg::SH_IDLE;
      pt_idx <= 2'd0;
    end else begin
      state  <= state_next;
      shape  <= shape_next;
      pt_idx <= pt_idx_next;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == mer_pkg::OP_EMIT |-> sts.out_free)
    else $error("point loaded while output register busy");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == mer_pkg::OP_EMIT && cmd.done) |-> cmd.last)
    else $error("shape end flagged on a point that is not last");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == mer_pkg::OP_EMIT && cmd.done) |=> shape == mer_pkg::SH_IDLE)
    else $error("shape still active after its final point");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == mer_pkg::OPN_START) |=> item_stall)
    else $error("item taken during start setup");

endmodule

`default_nettype wire

@@ rtl/core/mer_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mer_dpath #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 14
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire mer_pkg::dp_cmd_t             cmd,
  output mer_pkg::dp_sts_t                  sts,
  input  wire logic signed [COORD_BITS-1:0] center_x,
  input  wire logic signed [COORD_BITS-1:0] center_y,
  input  wire logic [RADIUS_BITS-1:0]       radius_x,
  input  wire logic [RADIUS_BITS-1:0]       radius_y,
  input  wire logic [31:0]                  color,
  output logic                              pixel_valid,
  input  wire logic                         pixel_stall,
  output logic signed [COORD_BITS:0]        pixel_x,
  output logic signed [COORD_BITS:0]        pixel_y,
  output logic [31:0]                       pixel_color,
  output logic                              last_of_step,
  output logic                              shape_done
);

  localparam int C   = COORD_BITS;
  localparam int R   = RADIUS_BITS;
  localparam int CW  = R + 2;
  localparam int SQW = 2 * R;
  localparam int PW  = 3 * R;
  localparam int SDW = 3 * R + 4;
  localparam int DW  = 3 * R + 8;
  localparam int SW  = ((C > CW) ? C : CW) + 1;

  logic [R-1:0]            rad_x, rad_y;
  logic signed [C-1:0]     cen_x, cen_y;
  logic [31:0]             col;
  logic [SQW-1:0]          rx2, ry2;
  logic signed [SDW-1:0]   step_dx, step_dy;
  logic signed [DW-1:0]    decision;
  logic signed [CW-1:0]    cur_x, cur_y;
  logic                    diag;

  logic [SQW-1:0]          mul_a;
  logic [R-1:0]            mul_b;
  logic [PW-1:0]           prod;

  logic signed [DW-1:0]    rx2_d, ry2_d, q_d, dx_d, dy_d;
  logic signed [SDW-1:0]   rx2_2, ry2_2;
  logic [SQW:0]            q_sum;
  logic signed [DW-1:0]    dec_inc1, dec_inc2, dec_rnd;
  logic signed [DW-1:0]    dec_upd;
  logic signed [CW-1:0]    ld_x, ld_y, cw_rx, cw_ry;
  logic signed [CW-1:0]    off_x, off_y;
  logic [SW-1:0]           sum_x, sum_y;
  logic                    dec_neg, dec_pos;

  always_comb begin
    case (cmd.op)
      mer_pkg::OP_SQ_RY: begin
        mul_a = {{(SQW-R){1'b0}}, rad_y};
        mul_b = rad_y;
      end
      mer_pkg::OP_MUL_DY: begin
        mul_a = rx2;
        mul_b = rad_y;
      end
      default: begin
        mul_a = {{(SQW-R){1'b0}}, rad_x};
        mul_b = rad_x;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign rx2_d = {{(DW-SQW){1'b0}}, rx2};
  assign ry2_d = {{(DW-SQW){1'b0}}, ry2};
  assign rx2_2 = {{(SDW-SQW-1){1'b0}}, rx2, 1'b0};
  assign ry2_2 = {{(SDW-SQW-1){1'b0}}, ry2, 1'b0};
  assign q_sum = {1'b0, rx2} + {{(SQW-1){1'b0}}, 2'b10};
  assign q_d   = {{(DW-SQW+1){1'b0}}, q_sum[SQW:2]};
  assign dx_d  = {{(DW-SDW){step_dx[SDW-1]}}, step_dx};
  assign dy_d  = {{(DW-SDW){step_dy[SDW-1]}}, step_dy};

  assign dec_neg  = decision[DW-1];
  assign dec_pos  = !decision[DW-1] && (decision != '0);
  assign dec_inc1 = decision + {{(DW-1){1'b0}}, 1'b1};
  assign dec_inc2 = decision + {{(DW-2){1'b0}}, 2'b10};
  // quarter, rounded half away from zero
  assign dec_rnd  = dec_neg ? (dec_inc1 >>> 2) : (dec_inc2 >>> 2);

  always_comb begin
    if (cmd.r2_dec) begin
      dec_upd = decision + rx2_d - dy_d + (diag ? '0 : dx_d);
    end else begin
      dec_upd = decision + ry2_d + dx_d - (diag ? dy_d : '0);
    end
  end

  assign cw_rx = {2'b00, radius_x};
  assign cw_ry = {2'b00, radius_y};

  always_comb begin
    ld_x = '0;
    ld_y = '0;
    if (radius_x == '0 && radius_y != '0) begin
      ld_y = -cw_ry;
    end else if (radius_y == '0 && radius_x != '0) begin
      ld_x = -cw_rx;
    end else if (radius_x != '0) begin
      ld_y = cw_ry;
    end
  end

  assign off_x = cmd.quad[0] ? -cur_x : cur_x;
  assign off_y = cmd.quad[1] ? -cur_y : cur_y;
  assign sum_x = {{(SW-C){cen_x[C-1]}}, cen_x} + {{(SW-CW){off_x[CW-1]}}, off_x};
  assign sum_y = {{(SW-C){cen_y[C-1]}}, cen_y} + {{(SW-CW){off_y[CW-1]}}, off_y};

  always_comb begin
    sts.rx_zero   = (rad_x == '0);
    sts.ry_zero   = (rad_y == '0);
    sts.x_zero    = (cur_x == '0);
    sts.y_zero    = (cur_y == '0);
    sts.y_le0     = cur_y[CW-1] || (cur_y == '0);
    sts.run_end_x = cur_x >= $signed({2'b00, rad_x});
    sts.run_end_y = cur_y >= $signed({2'b00, rad_y});
    sts.dx_lt_dy  = step_dx < step_dy;
    sts.out_free  = !pixel_valid || !pixel_stall;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      mer_pkg::OP_LOAD: begin
        cen_x   <= center_x;
        cen_y   <= center_y;
        col     <= color;
        rad_x   <= radius_x;
        rad_y   <= radius_y;
        cur_x   <= ld_x;
        cur_y   <= ld_y;
        step_dx <= '0;
        step_dy <= '0;
        diag    <= 1'b0;
      end
      mer_pkg::OP_SQ_RX:  rx2 <= prod[SQW-1:0];
      mer_pkg::OP_SQ_RY:  ry2 <= prod[SQW-1:0];
      mer_pkg::OP_MUL_DY: step_dy <= {{(SDW-PW-1){1'b0}}, prod, 1'b0};
      mer_pkg::OP_INIT_D: decision <= ry2_d - (dy_d >>> 1) + q_d;
      mer_pkg::OP_INC_X:  cur_x <= cur_x + {{(CW-1){1'b0}}, 1'b1};
      mer_pkg::OP_INC_Y:  cur_y <= cur_y + {{(CW-1){1'b0}}, 1'b1};
      mer_pkg::OP_R1_MOVE: begin
        cur_x   <= cur_x + {{(CW-1){1'b0}}, 1'b1};
        step_dx <= step_dx + ry2_2;
        diag    <= !dec_neg;
        if (!dec_neg) begin
          cur_y   <= cur_y - {{(CW-1){1'b0}}, 1'b1};
          step_dy <= step_dy - rx2_2;
        end
      end
      mer_pkg::OP_R1_DEC: decision <= dec_upd;
      mer_pkg::OP_N1:     decision <= (decision <<< 2) + (rx2_d <<< 2) - (q_d <<< 2);
      mer_pkg::OP_N2:     decision <= decision - ry2_d - (ry2_d <<< 1);
      mer_pkg::OP_N3:     decision <= decision - (dx_d <<< 1) - (dy_d <<< 1);
      mer_pkg::OP_ROUND:  decision <= dec_rnd;
      mer_pkg::OP_R2_MOVE: begin
        cur_y   <= cur_y - {{(CW-1){1'b0}}, 1'b1};
        step_dy <= step_dy - rx2_2;
        diag    <= dec_pos;
        if (!dec_pos) begin
          cur_x   <= cur_x + {{(CW-1){1'b0}}, 1'b1};
          step_dx <= step_dx + ry2_2;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == mer_pkg::OP_EMIT) begin
      pixel_x      <= sum_x[C:0];
      pixel_y      <= sum_y[C:0];
      pixel_color  <= col;
      last_of_step <= cmd.last;
      shape_done   <= cmd.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (cmd.op == mer_pkg::OP_EMIT) begin
      pixel_valid <= 1'b1;
    end else if (!pixel_stall) begin
      pixel_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/midpoint_ellipse_rasterizer.sv @@
// Midpoint ellipse outline rasterizer.
// Input channel (item_valid / item_stall): operation 0 starts a shape from
// center_x, center_y, radius_x, radius_y and color; operation 1 asks for the
// next outline position. A start gives no output item and aborts any shape
// in progress; a step with no shape active is taken and dropped.
// Output channel (pixel_valid / pixel_stall): one item per point, up to four
// mirrored points per step, last_of_step on the final one and shape_done on
// the final point of the whole outline.
// Timing: a start holds the input through its setup states (squares and
// initial terms through one shared multiplier). With a free output, an
// ellipse step loads its points (1 to 4) into the output register, one
// point per cycle, then moves and updates its decision; a run step emits
// its point, then moves; a shape's last step ends at its last point. The
// step from region one to region two adds the N1, N2, N3, ROUND and
// R2_MOVE states for the exact region-two start value. A step's first
// point is loaded from the emit state entered after its accept. A stalled
// output holds its item; emission pauses and item_stall stays high until
// the step's points and its position update are done.
// Reset clears the control state: no shape is active and no output is valid.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_ellipse_rasterizer #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 14
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire logic                         operation,
  input  wire logic signed [COORD_BITS-1:0] center_x,
  input  wire logic signed [COORD_BITS-1:0] center_y,
  input  wire logic [RADIUS_BITS-1:0]       radius_x,
  input  wire logic [RADIUS_BITS-1:0]       radius_y,
  input  wire logic [31:0]                  color,
  output logic                              pixel_valid,
  input  wire logic                         pixel_stall,
  output logic signed [COORD_BITS:0]        pixel_x,
  output logic signed [COORD_BITS:0]        pixel_y,
  output logic [31:0]                       pixel_color,
  output logic                              last_of_step,
  output logic                              shape_done
);

  mer_pkg::dp_cmd_t cmd;
  mer_pkg::dp_sts_t sts;

  mer_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .operation  (operation),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  mer_dpath #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius_x     (radius_x),
    .radius_y     (radius_y),
    .color        (color),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_color  (pixel_color),
    .last_of_step (last_of_step),
    .shape_done   (shape_done)
  );

endmodule

`default_nettype wire
